// ----- rtl/mafs_pkg.sv -----
`default_nettype none

package mafs_pkg;

   localparam int HeaderBytes = 4;
   localparam int ByteW = 8;
   localparam int LenW = 11;
   localparam int CountW = 24;
   localparam int KbpsW = 9;
   localparam int RateW = 16;
   localparam int FactorW = 18;
   localparam int ProdW = FactorW + KbpsW;
   localparam int NumW = 26;
   localparam int QuoW = 11;
   localparam int StepW = 4;

   localparam logic [ByteW-1:0] SyncByte = 8'hFF;
   localparam logic [2:0] SyncHigh = 3'b111;
   localparam logic [1:0] LayerThree = 2'b01;
   localparam logic [3:0] BrFree = 4'd0;
   localparam logic [3:0] BrBad = 4'd15;
   localparam logic [CountW-1:0] BadMax = 24'hFFFFFF;
   localparam logic [LenW-1:0] MinLenReset = 11'd21;
   localparam logic [FactorW-1:0] FactorMpeg1 = 18'd144000;
   localparam logic [FactorW-1:0] FactorMpeg2 = 18'd72000;

   localparam logic [1:0] VerMpeg2 = 2'd0;
   localparam logic [1:0] VerMpeg1 = 2'd1;
   localparam logic [1:0] VerMpeg25 = 2'd2;

   localparam logic KindHeader = 1'b0;
   localparam logic KindEnd = 1'b1;

   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic             end_of_data;
   } mafs_req_type;

   typedef struct packed {
      logic              result_kind;
      logic [1:0]        mpeg_version;
      logic [3:0]        bitrate_index;
      logic [1:0]        rate_index;
      logic              padding_bit;
      logic [1:0]        channel_mode;
      logic [1:0]        stereo_ext;
      logic [1:0]        emphasis;
      logic [3:0]        flag_bits;
      logic [LenW-1:0]   frame_bytes;
      logic              resynced;
      logic [CountW-1:0] bad_frames;
   } mafs_rsp_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic div_step;
      logic hdr_commit;
      logic end_commit;
   } mafs_cmd_type;

   typedef struct packed {
      logic hdr_full;
      logic div_last;
      logic hdr_ok;
   } mafs_status_type;

   function automatic logic [KbpsW-1:0] kbps_lookup(input logic mpeg1, input logic [3:0] br);
      logic [KbpsW-1:0] k;
      case (br)
         4'd1:    k = mpeg1 ? 9'd32  : 9'd8;
         4'd2:    k = mpeg1 ? 9'd40  : 9'd16;
         4'd3:    k = mpeg1 ? 9'd48  : 9'd24;
         4'd4:    k = mpeg1 ? 9'd56  : 9'd32;
         4'd5:    k = mpeg1 ? 9'd64  : 9'd40;
         4'd6:    k = mpeg1 ? 9'd80  : 9'd48;
         4'd7:    k = mpeg1 ? 9'd96  : 9'd56;
         4'd8:    k = mpeg1 ? 9'd112 : 9'd64;
         4'd9:    k = mpeg1 ? 9'd128 : 9'd80;
         4'd10:   k = mpeg1 ? 9'd160 : 9'd96;
         4'd11:   k = mpeg1 ? 9'd192 : 9'd112;
         4'd12:   k = mpeg1 ? 9'd224 : 9'd128;
         4'd13:   k = mpeg1 ? 9'd256 : 9'd144;
         4'd14:   k = mpeg1 ? 9'd320 : 9'd160;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic logic [RateW-1:0] rate_lookup(input logic [1:0] ver, input logic [1:0] fr);
      logic [RateW-1:0] r;
      r = 16'd50000;
      case (ver)
         VerMpeg2: begin
            case (fr)
               2'd0:    r = 16'd22050;
               2'd1:    r = 16'd24000;
               2'd2:    r = 16'd16000;
               default: r = 16'd50000;
            endcase
         end
         VerMpeg1: begin
            case (fr)
               2'd0:    r = 16'd44100;
               2'd1:    r = 16'd48000;
               2'd2:    r = 16'd32000;
               default: r = 16'd50000;
            endcase
         end
         default: begin
            case (fr)
               2'd0:    r = 16'd11025;
               2'd1:    r = 16'd12000;
               2'd2:    r = 16'd8000;
               default: r = 16'd50000;
            endcase
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/mafs_datapath.sv -----
`default_nettype none

module mafs_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mafs_pkg::mafs_req_type      req_data,
   input  wire logic                        csr_write_enable,
   input  wire logic [mafs_pkg::LenW-1:0]   csr_write_data,
   input  wire mafs_pkg::mafs_cmd_type      cmd,
   output mafs_pkg::mafs_status_type        status,
   output mafs_pkg::mafs_rsp_type           rsp_data
);
   import mafs_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_HEAD = 3'b010,
      PH_SKIP = 3'b100
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [23:0]        hdr_ff, hdr_in;
   logic [LenW-1:0]    pos_ff, pos_in;
   logic               skipped_ff, skipped_in;
   logic [CountW-1:0]  bad_ff, bad_in;
   logic [LenW-1:0]    min_ff, min_in;
   logic [ByteW-1:0]   b3_ff, b3_in;
   logic [NumW-1:0]    rem_ff, rem_in;
   logic [RateW-1:0]   div_ff, div_in;
   logic [QuoW-1:0]    quo_ff, quo_in;
   logic [StepW-1:0]   step_ff, step_in;
   mafs_rsp_type       rsp_ff, rsp_in;

   logic [ByteW-1:0]   b0, b1, b2;
   logic [1:0]         ver;
   logic [3:0]         br;
   logic [1:0]         fr;
   logic               pad;
   logic [LenW:0]      len_sum;
   logic [LenW-1:0]    frame_len;
   logic [LenW-1:0]    body_len;
   logic [LenW-1:0]    pos_dec;
   logic [FactorW-1:0] factor;
   logic [ProdW-1:0]   product;
   logic [NumW-1:0]    trial;
   logic [CountW-1:0]  bad_inc;
   logic               hdr_ok;
   logic               end_bad;

   assign b0 = hdr_ff[23:16];
   assign b1 = hdr_ff[15:8];
   assign b2 = hdr_ff[7:0];
   assign ver = b1[4] ? {1'b0, b1[3]} : VerMpeg25;
   assign br = b2[7:4];
   assign fr = b2[3:2];
   assign pad = b2[1];
   assign len_sum = {1'b0, quo_ff} + {{LenW{1'b0}}, pad};
   assign frame_len = len_sum[LenW-1:0];
   assign body_len = frame_len - LenW'(HeaderBytes);
   assign pos_dec = (pos_ff != '0) ? pos_ff - LenW'(1) : pos_ff;
   assign factor = ver[0] ? FactorMpeg1 : FactorMpeg2;
   assign product = ProdW'(factor) * ProdW'(kbps_lookup(ver[0], br));
   assign trial = NumW'(div_ff) << step_ff;
   assign bad_inc = (bad_ff == BadMax) ? bad_ff : bad_ff + CountW'(1);
   assign end_bad = skipped_ff || (phase_ff == PH_HEAD);

   assign hdr_ok = (b0 == SyncByte) && (b1[7:5] == SyncHigh) && (b1[2:1] == LayerThree)
                   && (br != BrFree) && (br != BrBad) && (len_sum >= {1'b0, min_ff});

   assign status.hdr_full = (phase_ff == PH_HEAD) && (pos_ff >= LenW'(HeaderBytes - 1));
   assign status.div_last = (step_ff == '0);
   assign status.hdr_ok = hdr_ok;
   assign rsp_data = rsp_ff;

   always_comb begin
      phase_in = phase_ff;
      hdr_in = hdr_ff;
      pos_in = pos_ff;
      skipped_in = skipped_ff;
      bad_in = bad_ff;
      min_in = csr_write_enable ? csr_write_data : min_ff;
      b3_in = cmd.accept ? req_data.data_byte : b3_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      rsp_in = rsp_ff;

      if (cmd.accept) begin
         case (phase_ff)
            PH_HEAD: begin
               if (!status.hdr_full) begin
                  hdr_in = {hdr_ff[15:0], req_data.data_byte};
                  pos_in = pos_ff + LenW'(1);
               end
            end
            PH_SKIP: begin
               pos_in = pos_dec;
               if (pos_dec == '0) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               if (req_data.data_byte == SyncByte) begin
                  phase_in = PH_HEAD;
                  hdr_in = 24'(SyncByte);
                  pos_in = LenW'(1);
               end else begin
                  phase_in = PH_HUNT;
                  skipped_in = 1'b1;
               end
            end
         endcase
      end

      if (cmd.mul) begin
         rem_in = product[NumW-1:0];
         div_in = rate_lookup(ver, fr);
         quo_in = '0;
         step_in = StepW'(QuoW - 1);
      end

      if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            quo_in[step_ff] = 1'b1;
         end
         step_in = step_ff - StepW'(1);
      end

      if (cmd.hdr_commit) begin
         hdr_in = '0;
         if (hdr_ok) begin
            rsp_in.result_kind = KindHeader;
            rsp_in.mpeg_version = ver;
            rsp_in.bitrate_index = br;
            rsp_in.rate_index = fr;
            rsp_in.padding_bit = pad;
            rsp_in.channel_mode = b3_ff[7:6];
            rsp_in.stereo_ext = b3_ff[5:4];
            rsp_in.emphasis = b3_ff[1:0];
            rsp_in.flag_bits = {b2[0], b3_ff[2], b3_ff[3], b1[0]};
            rsp_in.frame_bytes = frame_len;
            rsp_in.resynced = skipped_ff;
            rsp_in.bad_frames = skipped_ff ? bad_inc : bad_ff;
            bad_in = skipped_ff ? bad_inc : bad_ff;
            skipped_in = 1'b0;
            pos_in = body_len;
            phase_in = (body_len != '0) ? PH_SKIP : PH_HUNT;
         end else begin
            skipped_in = 1'b1;
            phase_in = PH_HUNT;
            pos_in = '0;
         end
      end

      if (cmd.end_commit) begin
         rsp_in = '0;
         rsp_in.result_kind = KindEnd;
         rsp_in.resynced = end_bad;
         rsp_in.bad_frames = end_bad ? bad_inc : bad_ff;
         bad_in = end_bad ? bad_inc : bad_ff;
         phase_in = PH_HUNT;
         hdr_in = '0;
         pos_in = '0;
         skipped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         hdr_ff <= '0;
         pos_ff <= '0;
         skipped_ff <= 1'b0;
         bad_ff <= '0;
         min_ff <= MinLenReset;
      end else begin
         phase_ff <= phase_in;
         hdr_ff <= hdr_in;
         pos_ff <= pos_in;
         skipped_ff <= skipped_in;
         bad_ff <= bad_in;
         min_ff <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      b3_ff <= b3_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- rtl/mafs_ctrl.sv -----
`default_nettype none

module mafs_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_last,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output mafs_pkg::mafs_cmd_type        cmd,
   input  wire mafs_pkg::mafs_status_type status
);
   import mafs_pkg::*;

   typedef enum logic [4:0] {
      ST_RUN = 5'b00001,
      ST_MUL = 5'b00010,
      ST_DIV = 5'b00100,
      ST_HDR = 5'b01000,
      ST_END = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_RUN);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      last_in = last_ff;
      case (state_ff)
         ST_RUN: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               last_in = req_last;
               if (status.hdr_full) begin
                  state_in = ST_MUL;
               end else if (req_last) begin
                  state_in = ST_END;
               end
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            if (!status.hdr_ok || out_free) begin
               cmd.hdr_commit = 1'b1;
               state_in = last_ff ? ST_END : ST_RUN;
            end
         end
         ST_END: begin
            if (out_free) begin
               cmd.end_commit = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      if ((cmd.hdr_commit && status.hdr_ok) || cmd.end_commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ((cmd.hdr_commit && status.hdr_ok) || cmd.end_commit) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_mul_after_header: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> $past(cmd.accept && status.hdr_full))
      else $error("length multiply without a complete header");

   a_div_complete: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_HDR) && ($past(state_ff) != ST_HDR)) |-> $past(status.div_last))
      else $error("header check before divide finished");

   a_end_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.hdr_commit |=> ((state_ff == ST_END) == $past(last_ff)))
      else $error("end of data result lost after header");
`endif

endmodule

`default_nettype wire

// ----- rtl/mpeg_audio_frame_scanner.sv -----
`default_nettype none
// Order: a non-header byte is taken without a stall; an end-of-data result is registered in the
//   end state after its byte, a header result after its fourth byte through multiply, 11-step
//   divide and check, with the end-of-data result following once the output register frees.
// Throughput: 1 byte per cycle, except stalls after each fourth header byte (restoring divider
//   for frame length) and after an end-of-data byte, plus waits on a full result register.
// Reset: synchronous; scanning state and bad-frame count clear, minimum length returns to 21.
module mpeg_audio_frame_scanner (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire mafs_pkg::mafs_req_type    req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output mafs_pkg::mafs_rsp_type         rsp_data,
   input  wire logic                      csr_write_enable,
   input  wire logic [mafs_pkg::LenW-1:0] csr_write_data
);
   import mafs_pkg::*;

   mafs_cmd_type    cmd;
   mafs_status_type status;

   mafs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.end_of_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mafs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data)
   );

endmodule

`default_nettype wire
